FILE: hdl/rcpw_pkg.sv
// Shared constants, types and register codes for the pulse width capture core.
`timescale 1ns / 1ps
`default_nettype none

package rcpw_pkg;

  // Defaults for the top-level parameters.
  localparam int CHANNELS_DEF  = 4;
  localparam int TIME_BITS_DEF = 32;

  // Fixed field widths of the words on the channels.
  localparam int PIN_BITS     = 4;
  localparam int TIME_IN_BITS = 32;
  localparam int WIDTH_BITS   = 16;
  localparam int NUM_OUT_CH   = 4;
  localparam int CFG_IDX_BITS = 2;

  // Pin assignment of the output channels.
  localparam int CH_ROLL     = 0;
  localparam int CH_PITCH    = 1;
  localparam int CH_THROTTLE = 2;
  localparam int CH_YAW      = 3;

  // Register codes on the configuration port.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DEADBAND_LOW  = 2'd0,
    CFG_DEADBAND_HIGH = 2'd1,
    CFG_CENTER_VALUE  = 2'd2
  } cfg_index_t;

  // Register values after reset.
  localparam logic [WIDTH_BITS-1:0] DEADBAND_LOW_RST  = 16'd1492;
  localparam logic [WIDTH_BITS-1:0] DEADBAND_HIGH_RST = 16'd1508;
  localparam logic [WIDTH_BITS-1:0] CENTER_VALUE_RST  = 16'd1500;

  // Throttle scaling: (w - 1000) * 4 / 5 + 1000, truncated toward zero.
  // The magnitude 4*|w - 1000| stays below 2^18, and x * ceil(2^22 / 5) >> 22
  // equals x / 5 for every x below 2^22.
  localparam int                    THR_MAG_BITS   = 18;
  localparam int                    THR_RECIP_BITS = 20;
  localparam int                    THR_SHIFT      = 22;
  localparam int                    THR_PROD_BITS  = THR_MAG_BITS + THR_RECIP_BITS;
  localparam logic [WIDTH_BITS-1:0] THR_OFFSET     = 16'd1000;
  localparam logic [THR_RECIP_BITS-1:0] THR_RECIP  = 20'd838861;

  // What one lane reports to the merging stage.
  typedef struct packed {
    logic                  done;
    logic [WIDTH_BITS-1:0] width;
  } lane_status_t;

  // Stick conditioning registers.
  typedef struct packed {
    logic [WIDTH_BITS-1:0] deadband_low;
    logic [WIDTH_BITS-1:0] deadband_high;
    logic [WIDTH_BITS-1:0] center_value;
  } rcpw_cfg_t;

endpackage

`default_nettype wire

FILE: hdl/rcpw_ifs.sv
// Valid/ready channel interfaces for the sample words and the result words.
`timescale 1ns / 1ps
`default_nettype none

interface rcpw_in_if import rcpw_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [PIN_BITS-1:0]     pin_levels;
  logic [TIME_IN_BITS-1:0] time_us;

  modport source (output valid, output pin_levels, output time_us, input ready);
  modport sink   (input valid, input pin_levels, input time_us, output ready);
endinterface

interface rcpw_out_if import rcpw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [WIDTH_BITS-1:0] roll_out;
  logic [WIDTH_BITS-1:0] pitch_out;
  logic [WIDTH_BITS-1:0] yaw_out;
  logic [WIDTH_BITS-1:0] throttle_out;
  logic [WIDTH_BITS-1:0] throttle_raw;
  logic [PIN_BITS-1:0]   pulse_done;

  modport source (output valid, output roll_out, output pitch_out, output yaw_out,
                  output throttle_out, output throttle_raw, output pulse_done,
                  input ready);
  modport sink   (input valid, input roll_out, input pitch_out, input yaw_out,
                  input throttle_out, input throttle_raw, input pulse_done,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/rcpw_lane.sv
// One capture lane: edge detection, rise timestamp and saturated pulse width.
`timescale 1ns / 1ps
`default_nettype none

module rcpw_lane import rcpw_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load,
  input  wire logic                 level,
  input  wire logic [TIME_BITS-1:0] now,
  output lane_status_t              status
);

  // Difference width with room for at least one bit above the 16-bit result.
  localparam int DW = (TIME_BITS > WIDTH_BITS) ? TIME_BITS : WIDTH_BITS + 1;

  logic                  prev_r;
  logic [TIME_BITS-1:0]  rise_r;
  logic [WIDTH_BITS-1:0] width_r;

  logic [TIME_BITS-1:0]  diff;
  logic [DW-1:0]         diff_ext;
  logic [WIDTH_BITS-1:0] width_nxt;
  logic                  rise;
  logic                  fall;

  // Edge detection against the last seen level.
  assign rise = level && !prev_r;
  assign fall = !level && prev_r;

  // High time modulo the timestamp width, saturated to 16 bits.
  assign diff      = now - rise_r;
  assign diff_ext  = DW'(diff);
  assign width_nxt = (|diff_ext[DW-1:WIDTH_BITS]) ? {WIDTH_BITS{1'b1}}
                                                   : diff_ext[WIDTH_BITS-1:0];

  // Lane state advances on every accepted sample word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 1'b0;
      rise_r  <= '0;
      width_r <= '0;
    end else if (load) begin
      prev_r <= level;
      if (rise) begin
        rise_r <= now;
      end
      if (fall) begin
        width_r <= width_nxt;
      end
    end
  end

  // The falling edge flag refers to the sample on the port; the width is
  // the stored value and reflects the last accepted sample.
  assign status.done  = fall;
  assign status.width = width_r;

endmodule

`default_nettype wire

FILE: hdl/rcpw_merge.sv
// Merging pipeline: deadband, throttle scaling and the output register.
`timescale 1ns / 1ps
`default_nettype none

module rcpw_merge import rcpw_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_fire,
  input  wire logic [PIN_BITS-1:0]   done_in,
  input  wire logic [WIDTH_BITS-1:0] width_in [NUM_OUT_CH],
  input  wire rcpw_cfg_t             cfg,
  output logic                       take,
  rcpw_out_if.source                 out_word
);

  // Stage valids and the per-stage advance conditions.
  logic s1_v_r, s2_v_r, out_v_r;
  logic ready_out, ready_s2, ready_s1;

  logic [PIN_BITS-1:0] s1_done_r;

  logic [WIDTH_BITS-1:0]    s2_roll_r, s2_pitch_r, s2_yaw_r, s2_raw_r;
  logic [PIN_BITS-1:0]      s2_done_r;
  logic                     s2_neg_r;
  logic [THR_PROD_BITS-1:0] s2_prod_r;

  logic [WIDTH_BITS-1:0] out_roll_r, out_pitch_r, out_yaw_r, out_thr_r, out_raw_r;
  logic [PIN_BITS-1:0]   out_done_r;

  logic [WIDTH_BITS-1:0]    thr_w;
  logic                     thr_neg;
  logic [THR_MAG_BITS-1:0]  thr_mag;
  logic [THR_PROD_BITS-1:0] thr_prod;
  logic [WIDTH_BITS-1:0]    thr_quot;
  logic [WIDTH_BITS-1:0]    thr_nxt;

  assign ready_out = !out_v_r || out_word.ready;
  assign ready_s2  = !s2_v_r || ready_out;
  assign ready_s1  = !s1_v_r || ready_s2;
  assign take      = ready_s1;

  // Stick value: center inside the deadband, the raw width outside it.
  function automatic logic [WIDTH_BITS-1:0] stick(input logic [WIDTH_BITS-1:0] w,
                                                  input rcpw_cfg_t c);
    logic inside_band;
    inside_band = (w >= c.deadband_low) && (w <= c.deadband_high);
    return inside_band ? c.center_value : w;
  endfunction

  // Throttle magnitude 4*|w - 1000| and its scaling by one fifth.
  assign thr_w    = width_in[CH_THROTTLE];
  assign thr_neg  = thr_w < THR_OFFSET;
  assign thr_mag  = {(thr_neg ? THR_OFFSET - thr_w : thr_w - THR_OFFSET), 2'b00};
  assign thr_prod = THR_PROD_BITS'(thr_mag) * THR_PROD_BITS'(THR_RECIP);

  // Quotient, sign and offset back to the 1000 us base.
  assign thr_quot = s2_prod_r[THR_PROD_BITS-1:THR_SHIFT];
  assign thr_nxt  = s2_neg_r ? THR_OFFSET - thr_quot : THR_OFFSET + thr_quot;

  // Stage valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (ready_s1) begin
        s1_v_r <= in_fire;
      end
      if (ready_s2) begin
        s2_v_r <= s1_v_r;
      end
      if (ready_out) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // Stage payloads; the lane widths already hold the state after the word in stage 1.
  always_ff @(posedge clk) begin
    if (ready_s1) begin
      s1_done_r <= done_in;
    end
    if (ready_s2) begin
      s2_roll_r  <= stick(width_in[CH_ROLL], cfg);
      s2_pitch_r <= stick(width_in[CH_PITCH], cfg);
      s2_yaw_r   <= stick(width_in[CH_YAW], cfg);
      s2_raw_r   <= thr_w;
      s2_neg_r   <= thr_neg;
      s2_prod_r  <= thr_prod;
      s2_done_r  <= s1_done_r;
    end
    if (ready_out) begin
      out_roll_r  <= s2_roll_r;
      out_pitch_r <= s2_pitch_r;
      out_yaw_r   <= s2_yaw_r;
      out_thr_r   <= thr_nxt;
      out_raw_r   <= s2_raw_r;
      out_done_r  <= s2_done_r;
    end
  end

  assign out_word.valid        = out_v_r;
  assign out_word.roll_out     = out_roll_r;
  assign out_word.pitch_out    = out_pitch_r;
  assign out_word.yaw_out      = out_yaw_r;
  assign out_word.throttle_out = out_thr_r;
  assign out_word.throttle_raw = out_raw_r;
  assign out_word.pulse_done   = out_done_r;

endmodule

`default_nettype wire

FILE: hdl/rc_pulse_width_capture_core.sv
// Top level: configuration registers, capture lanes and the merging pipeline.
// A result word is valid once its sample word has passed the stage 1, stage 2 and output registers.
// Throughput: one sample word per cycle while the output takes words; each lane updates in the accept cycle.
// The three-stage merge pipeline stalls stage by stage, so bubbles are absorbed.
// Reset (synchronous, rst_n low): lane levels, timestamps and widths clear to zero,
// the deadband and center registers return to 1492, 1508 and 1500, no word is held.
`timescale 1ns / 1ps
`default_nettype none

module rc_pulse_width_capture_core import rcpw_pkg::*; #(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  rcpw_in_if.sink                      in_word,
  rcpw_out_if.source                   out_word,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [WIDTH_BITS-1:0]   cfg_wdata
);

  rcpw_cfg_t cfg_r;

  logic                  in_fire;
  logic                  take;
  logic [TIME_BITS-1:0]  now;
  lane_status_t          lane_st [CHANNELS];
  logic [WIDTH_BITS-1:0] width_sel [NUM_OUT_CH];
  logic [PIN_BITS-1:0]   done_sel;

  assign in_word.ready = take;
  assign in_fire       = in_word.valid && take;
  assign now           = TIME_BITS'(in_word.time_us);

  // Configuration register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadband_low  <= DEADBAND_LOW_RST;
      cfg_r.deadband_high <= DEADBAND_HIGH_RST;
      cfg_r.center_value  <= CENTER_VALUE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEADBAND_LOW:  cfg_r.deadband_low  <= cfg_wdata;
        CFG_DEADBAND_HIGH: cfg_r.deadband_high <= cfg_wdata;
        CFG_CENTER_VALUE:  cfg_r.center_value  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // One capture lane per channel; channels without a pin see a low level.
  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    logic level;
    if (i < PIN_BITS) begin : g_pin
      assign level = in_word.pin_levels[i];
    end else begin : g_nopin
      assign level = 1'b0;
    end

    rcpw_lane #(
      .TIME_BITS (TIME_BITS)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .load   (in_fire),
      .level  (level),
      .now    (now),
      .status (lane_st[i])
    );
  end

  // Gather the four output channels; a missing channel reads as zero.
  for (genvar j = 0; j < NUM_OUT_CH; j++) begin : g_sel
    if (j < CHANNELS) begin : g_have
      assign width_sel[j] = lane_st[j].width;
      assign done_sel[j]  = lane_st[j].done;
    end else begin : g_none
      assign width_sel[j] = '0;
      assign done_sel[j]  = 1'b0;
    end
  end

  rcpw_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .done_in  (done_sel),
    .width_in (width_sel),
    .cfg      (cfg_r),
    .take     (take),
    .out_word (out_word)
  );

  // The input stalls only while a finished result waits at the output.
  a_stall_means_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    !in_word.ready |-> (out_word.valid && !out_word.ready))
    else $error("input stalled without a pending result word");

  // A pin sampled high can never complete a pulse in the same word.
  a_no_done_while_high: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_word.pin_levels[CH_ROLL]) |-> !done_sel[CH_ROLL])
    else $error("pulse completion flagged on a high roll pin");

  // The throttle mapping stays inside its reachable range.
  a_throttle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid |-> (out_word.throttle_out >= 16'd200 &&
                        out_word.throttle_out <= 16'd52628))
    else $error("throttle output out of range");

endmodule

`default_nettype wire

FILE: test/rc_pulse_width_capture_core_test.sv
// Self-checking testbench for the pulse width capture core, with a scoreboard and random pulse trains.
`timescale 1ns / 1ps

module rc_pulse_width_capture_core_test;
  import rcpw_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 5;
  localparam int LATENCY       = 3;
  localparam int MAX_WAIT      = 11;
  localparam int LONG_HOLD     = 64;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 110;
  localparam int NUM_PHASES    = 8;
  localparam int MAX_REPORTS   = 30;
  localparam int NUM_PINS      = 4;
  localparam int WIDTH_MAX     = 65535;
  localparam int THR_BASE_US   = 1000;
  localparam int THR_SPAN_NUM  = 800;
  localparam int THR_SPAN_DEN  = 1000;

  // The index past the last register; writes to it must be ignored.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_INDEX = 2'd3;

  // One result word as seen on the output channel.
  typedef struct packed {
    logic [WIDTH_BITS-1:0] roll_out;
    logic [WIDTH_BITS-1:0] pitch_out;
    logic [WIDTH_BITS-1:0] yaw_out;
    logic [WIDTH_BITS-1:0] throttle_out;
    logic [WIDTH_BITS-1:0] throttle_raw;
    logic [PIN_BITS-1:0]   pulse_done;
  } capture_word_t;

  // Tracks pin levels, rise stamps and widths, and queues the expected words.
  class capture_scoreboard;
    bit [NUM_PINS-1:0]       level_q;
    logic [TIME_IN_BITS-1:0] rise_stamp [NUM_PINS];
    logic [WIDTH_BITS-1:0]   width_q [NUM_PINS];
    logic [WIDTH_BITS-1:0]   db_low;
    logic [WIDTH_BITS-1:0]   db_high;
    logic [WIDTH_BITS-1:0]   center;
    capture_word_t           expected_words [$];
    int errors;
    int samples;
    int results;
    int pulses;
    int saturated;
    int wrapped;

    function void clear();
      level_q = '0;
      for (int ch = 0; ch < NUM_PINS; ch++) begin
        rise_stamp[ch] = '0;
        width_q[ch] = '0;
      end
      db_low = DEADBAND_LOW_RST;
      db_high = DEADBAND_HIGH_RST;
      center = CENTER_VALUE_RST;
      expected_words.delete();
      errors = 0;
      samples = 0;
      results = 0;
      pulses = 0;
      saturated = 0;
      wrapped = 0;
    endfunction

    function void set_register(logic [CFG_IDX_BITS-1:0] idx, logic [WIDTH_BITS-1:0] val);
      case (idx)
        CFG_DEADBAND_LOW: db_low = val;
        CFG_DEADBAND_HIGH: db_high = val;
        CFG_CENTER_VALUE: center = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function logic [WIDTH_BITS-1:0] stick(logic [WIDTH_BITS-1:0] w);
      return (w >= db_low && w <= db_high) ? center : w;
    endfunction

    function logic [WIDTH_BITS-1:0] scale_throttle(logic [WIDTH_BITS-1:0] w);
      int v;
      v = (int'(w) - THR_BASE_US) * THR_SPAN_NUM;
      v = v / THR_SPAN_DEN + THR_BASE_US;
      return v[WIDTH_BITS-1:0];
    endfunction

    // Edge detection per pin, then the conditioned outputs from the stored widths.
    function void note_sample(logic [PIN_BITS-1:0] pins, logic [TIME_IN_BITS-1:0] stamp);
      capture_word_t w;
      logic [TIME_IN_BITS-1:0] span;
      w = '0;
      for (int ch = 0; ch < NUM_PINS; ch++) begin
        if (pins[ch]) begin
          if (!level_q[ch]) begin
            level_q[ch] = 1'b1;
            rise_stamp[ch] = stamp;
          end
        end else if (level_q[ch]) begin
          span = stamp - rise_stamp[ch];
          if (stamp < rise_stamp[ch]) wrapped++;
          if (span > WIDTH_MAX) saturated++;
          level_q[ch] = 1'b0;
          width_q[ch] = (span > WIDTH_MAX) ? WIDTH_MAX[WIDTH_BITS-1:0] : span[WIDTH_BITS-1:0];
          w.pulse_done[ch] = 1'b1;
          pulses++;
        end
      end
      w.roll_out = stick(width_q[CH_ROLL]);
      w.pitch_out = stick(width_q[CH_PITCH]);
      w.yaw_out = stick(width_q[CH_YAW]);
      w.throttle_out = scale_throttle(width_q[CH_THROTTLE]);
      w.throttle_raw = width_q[CH_THROTTLE];
      expected_words.push_back(w);
      samples++;
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_REPORTS) $display("MISMATCH: %s", what);
    endtask

    task compare_field(string name, logic [WIDTH_BITS-1:0] got, logic [WIDTH_BITS-1:0] want);
      if (got !== want)
        report($sformatf("word %0d %s got %0d expected %0d", results, name, got, want));
    endtask

    // Compare one accepted word with the oldest expectation.
    task check_result(capture_word_t got);
      capture_word_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("word %0d arrived with nothing expected", results));
      end else begin
        want = expected_words.pop_front();
        compare_field("roll_out", got.roll_out, want.roll_out);
        compare_field("pitch_out", got.pitch_out, want.pitch_out);
        compare_field("yaw_out", got.yaw_out, want.yaw_out);
        compare_field("throttle_out", got.throttle_out, want.throttle_out);
        compare_field("throttle_raw", got.throttle_raw, want.throttle_raw);
        compare_field("pulse_done", WIDTH_BITS'(got.pulse_done), WIDTH_BITS'(want.pulse_done));
      end
      results++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [WIDTH_BITS-1:0] cfg_wdata;

  rcpw_in_if  in_word ();
  rcpw_out_if out_word ();

  rc_pulse_width_capture_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  capture_scoreboard sb;

  bit sender_idles;
  bit receiver_idles;
  bit hold_request;
  int settings_applied;
  int idle_cycles = 0;

  // State of the pulse train generator, kept in 64 bits so the wrap is free.
  longint unsigned now_us;
  longint unsigned due_us [NUM_PINS];
  bit [NUM_PINS-1:0] gen_level;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Watchdog: ends the run when neither channel moves a word for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_word.valid === 1'b1 && in_word.ready === 1'b1) ||
          (out_word.valid === 1'b1 && out_word.ready === 1'b1)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("rc_pulse_width_capture_core_test: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offer one sample word and wait until the block takes it.
  task send_sample(logic [PIN_BITS-1:0] pins, logic [TIME_IN_BITS-1:0] stamp);
    int gap;
    gap = sender_idles ? $urandom_range(0, MAX_WAIT) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_word.valid <= 1'b0;
    end
    @(negedge clk);
    in_word.valid <= 1'b1;
    in_word.pin_levels <= pins;
    in_word.time_us <= stamp;
    do @(posedge clk); while (in_word.ready !== 1'b1);
    sb.note_sample(pins, stamp);
  endtask

  task go_quiet();
    @(negedge clk);
    in_word.valid <= 1'b0;
  endtask

  // Wait for every expected word, then let the pipeline settle.
  task drain_results();
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task write_register(logic [CFG_IDX_BITS-1:0] idx, logic [WIDTH_BITS-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_register(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task apply_setting(int lo, int hi, int ctr);
    write_register(CFG_DEADBAND_LOW, lo[WIDTH_BITS-1:0]);
    write_register(CFG_DEADBAND_HIGH, hi[WIDTH_BITS-1:0]);
    write_register(CFG_CENTER_VALUE, ctr[WIDTH_BITS-1:0]);
    settings_applied++;
  endtask

  // High times: mostly normal stick range, some hugging the deadband edges,
  // some tiny and some long enough to saturate.
  function int pick_width();
    int r;
    int w;
    r = $urandom_range(0, 99);
    if (r < 50) w = $urandom_range(1000, 2000);
    else if (r < 65) w = $urandom_range(1488, 1512);
    else if (r < 75) w = int'(sb.db_low) + int'($urandom_range(0, 4)) - 2;
    else if (r < 80) w = int'(sb.db_high) + int'($urandom_range(0, 4)) - 2;
    else if (r < 88) w = $urandom_range(0, 1100);
    else if (r < 94) w = $urandom_range(2000, 5000);
    else w = $urandom_range(60000, 70000);
    return (w < 0) ? 0 : w;
  endfunction

  function int pick_gap();
    return ($urandom_range(0, 99) < 5) ? 0 : $urandom_range(200, 3000);
  endfunction

  // Next sample of the pulse trains: the clock jumps to the nearest edge when
  // one is due, with a share of noise samples and large jumps of the timestamp.
  task next_random_sample(output logic [PIN_BITS-1:0] pins, output logic [TIME_IN_BITS-1:0] stamp);
    int r;
    longint unsigned nxt;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      now_us += $urandom_range(0, 5000);
      pins = PIN_BITS'($urandom);
    end else begin
      if (r < 10) now_us += $urandom;
      nxt = now_us + ((r < 13) ? 0 : $urandom_range(1, 400));
      for (int ch = 0; ch < NUM_PINS; ch++)
        if (due_us[ch] > now_us && due_us[ch] < nxt) nxt = due_us[ch];
      now_us = nxt;
      for (int ch = 0; ch < NUM_PINS; ch++) begin
        if (due_us[ch] <= now_us) begin
          gen_level[ch] = ~gen_level[ch];
          due_us[ch] = now_us + (gen_level[ch] ? pick_width() : pick_gap());
        end
      end
      pins = gen_level;
    end
    stamp = now_us[TIME_IN_BITS-1:0];
  endtask

  // Hand-picked samples: reset outputs, deadband edges, throttle corners,
  // zero width, a wrapped timestamp and saturation.
  task directed_samples();
    send_sample(4'b0000, 32'd0);
    send_sample(4'b1111, 32'd100);
    send_sample(4'b0000, 32'd1600);
    send_sample(4'b1111, 32'd5000);
    send_sample(4'b1110, 32'd6491);
    send_sample(4'b1100, 32'd6492);
    send_sample(4'b1000, 32'd6508);
    send_sample(4'b0000, 32'd6509);
    send_sample(4'b0100, 32'd7000);
    send_sample(4'b0000, 32'd7999);
    send_sample(4'b0100, 32'd8000);
    send_sample(4'b0000, 32'd9000);
    send_sample(4'b0100, 32'd9000);
    send_sample(4'b0000, 32'd9000);
    send_sample(4'b1111, 32'hFFFF_FF00);
    send_sample(4'b0000, 32'h0000_0400);
    send_sample(4'b1111, 32'h1000_0000);
    send_sample(4'b0000, 32'h1000_FFFF);
    send_sample(4'b1111, 32'h2000_0000);
    send_sample(4'b0000, 32'h2001_0000);
    send_sample(4'b1111, 32'hFFFF_FFFF);
    send_sample(4'b1111, 32'hFFFF_FFFF);
    send_sample(4'b0000, 32'h0000_07D0);
  endtask

  // Result side: random hold-offs, one long one when asked.
  initial begin : result_sink
    int gap;
    capture_word_t got;
    @(posedge rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        gap = LONG_HOLD;
      end else begin
        gap = receiver_idles ? $urandom_range(0, MAX_WAIT) : 0;
      end
      repeat (gap) begin
        @(negedge clk);
        out_word.ready <= 1'b0;
      end
      @(negedge clk);
      out_word.ready <= 1'b1;
      do @(posedge clk); while (out_word.valid !== 1'b1);
      got.roll_out = out_word.roll_out;
      got.pitch_out = out_word.pitch_out;
      got.yaw_out = out_word.yaw_out;
      got.throttle_out = out_word.throttle_out;
      got.throttle_raw = out_word.throttle_raw;
      got.pulse_done = out_word.pulse_done;
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    logic [PIN_BITS-1:0] pins;
    logic [TIME_IN_BITS-1:0] stamp;
    int lo;
    sb = new;
    sb.clear();
    cfg_we = 1'b0;
    cfg_index = CFG_DEADBAND_LOW;
    cfg_wdata = '0;
    in_word.valid = 1'b0;
    in_word.pin_levels = '0;
    in_word.time_us = '0;
    out_word.ready = 1'b0;
    sender_idles = 1'b0;
    receiver_idles = 1'b1;
    hold_request = 1'b0;
    settings_applied = 1;
    now_us = 64'h0000_0001_0000_1000;
    gen_level = '0;
    for (int ch = 0; ch < NUM_PINS; ch++) due_us[ch] = now_us + pick_gap();

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    directed_samples();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // Registers change only with the block empty.
      if (phase > 0) begin
        go_quiet();
        drain_results();
        case (phase)
          1: apply_setting(0, WIDTH_MAX, 0);
          2: apply_setting(WIDTH_MAX, 0, WIDTH_MAX);
          3: apply_setting(1000, 2000, 1500);
          4: begin
            lo = $urandom_range(0, WIDTH_MAX - 600);
            apply_setting(lo, lo + $urandom_range(0, 600), $urandom_range(0, WIDTH_MAX));
            write_register(CFG_SPARE_INDEX, WIDTH_BITS'($urandom));
          end
          5: apply_setting(0, 0, WIDTH_MAX);
          6: apply_setting(WIDTH_MAX, WIDTH_MAX, $urandom_range(0, WIDTH_MAX));
          default: apply_setting(DEADBAND_LOW_RST, DEADBAND_HIGH_RST, CENTER_VALUE_RST);
        endcase
      end
      sender_idles = (phase % 3 != 0);
      receiver_idles = (phase % 3 != 0);
      // Hold the result side off while samples keep coming, so the block backs up.
      if (phase == 2) hold_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 4 && n == PHASE_ITEMS / 2) begin
          go_quiet();
          while (sb.pending() != 0) @(posedge clk);
        end
        next_random_sample(pins, stamp);
        send_sample(pins, stamp);
      end
    end

    go_quiet();
    drain_results();
    $display("Run covered %0d samples and %0d result words over %0d register settings.",
             sb.samples, sb.results, settings_applied);
    $display("It completed %0d pulses, %0d of them saturated and %0d across a timestamp wrap.",
             sb.pulses, sb.saturated, sb.wrapped);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("rc_pulse_width_capture_core_test: clean");
    end else begin
      $display("rc_pulse_width_capture_core_test: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/rcpw_pkg.sv
hdl/rcpw_ifs.sv
hdl/rcpw_lane.sv
hdl/rcpw_merge.sv
hdl/rc_pulse_width_capture_core.sv
test/rc_pulse_width_capture_core_test.sv
